### rtl/mmnorm_pkg.sv
`default_nettype none
package mmnorm_pkg;

   localparam int PIXEL_W     = 32;
   localparam int LEVEL_W     = 16;
   localparam int OUT_BITS_W  = 5;
   localparam int PRODUCT_W   = PIXEL_W + LEVEL_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int STEP_CNT_W  = $clog2(LEVEL_W + 1);

   localparam logic [OUT_BITS_W-1:0] OUT_BITS_RESET = OUT_BITS_W'(8);
   localparam logic [OUT_BITS_W-1:0] OUT_BITS_MAX   = OUT_BITS_W'(LEVEL_W);

   localparam logic signed [PIXEL_W-1:0] PIX_NEG = {1'b1, {(PIXEL_W-1){1'b0}}};
   localparam logic signed [PIXEL_W-1:0] PIX_POS = {1'b0, {(PIXEL_W-1){1'b1}}};

   typedef enum logic [1:0] {
      FUNC_RESTART = 2'd0,
      FUNC_GATHER  = 2'd1,
      FUNC_MAP     = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef struct packed {
      func_type                   func;
      logic signed [PIXEL_W-1:0]  pixel;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               flat;
   } rsp_type;

   // One map request after classification. A direct job already carries its
   // level; otherwise the back end works out floor(top * diff / span).
   typedef struct packed {
      logic                 direct;
      logic [LEVEL_W-1:0]   level;
      logic                 flat;
      logic [PIXEL_W-1:0]   diff;
      logic [PIXEL_W-1:0]   span;
      logic [LEVEL_W-1:0]   top;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_MUL  = 2'd1,
      BK_DIV  = 2'd2
   } back_state_type;

endpackage
`default_nettype wire

### rtl/mmnorm_front.sv
`default_nettype none
module mmnorm_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  mmnorm_pkg::req_type                   req_item,
   input  logic                                  csr_wr_en,
   input  logic [mmnorm_pkg::OUT_BITS_W-1:0]     csr_wr_data,
   input  logic                                  queue_full,
   output logic                                  push_valid,
   output mmnorm_pkg::job_type                   push_job
);
   import mmnorm_pkg::*;

   logic [OUT_BITS_W-1:0]      out_bits_ff, out_bits_in;
   logic signed [PIXEL_W-1:0]  run_min_ff, run_min_in;
   logic signed [PIXEL_W-1:0]  run_max_ff, run_max_in;
   logic                       accept;
   logic                       is_gather;
   logic                       is_sentinel;
   logic signed [PIXEL_W-1:0]  base_min, base_max;
   logic [OUT_BITS_W-1:0]      n_clamp;
   logic [LEVEL_W-1:0]         top;
   logic [PIXEL_W-1:0]         span_full, diff_full;
   job_type                    job;

   assign req_stall   = queue_full;
   assign accept      = req_valid && !req_stall;
   assign is_gather   = (req_item.func == FUNC_RESTART) || (req_item.func == FUNC_GATHER);
   assign is_sentinel = (req_item.pixel == PIX_NEG) || (req_item.pixel == PIX_POS);

   always_comb begin
      base_min = (req_item.func == FUNC_RESTART) ? PIX_POS : run_min_ff;
      base_max = (req_item.func == FUNC_RESTART) ? PIX_NEG : run_max_ff;
      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      if (accept && is_gather) begin
         run_min_in = (!is_sentinel && req_item.pixel < base_min) ? req_item.pixel : base_min;
         run_max_in = (!is_sentinel && req_item.pixel > base_max) ? req_item.pixel : base_max;
      end
      out_bits_in = csr_wr_en ? csr_wr_data : out_bits_ff;
   end

   // Full scale 2^N-1 with N held to the range one to sixteen.
   always_comb begin
      if (out_bits_ff == '0) begin
         n_clamp = OUT_BITS_W'(1);
      end else if (out_bits_ff > OUT_BITS_MAX) begin
         n_clamp = OUT_BITS_MAX;
      end else begin
         n_clamp = out_bits_ff;
      end
      top = LEVEL_W'(((LEVEL_W+1)'(1) << n_clamp) - (LEVEL_W+1)'(1));
   end

   // For an interior pixel both differences are positive and fit in 32 bits.
   assign span_full = run_max_ff - run_min_ff;
   assign diff_full = req_item.pixel - run_min_ff;

   // Classification of a map request against the range as it stands now.
   always_comb begin
      job.direct = 1'b1;
      job.level  = '0;
      job.flat   = 1'b0;
      job.diff   = diff_full;
      job.span   = span_full;
      job.top    = top;
      if (run_min_ff == run_max_ff) begin
         job.flat = 1'b1;
      end else if (req_item.pixel == PIX_NEG) begin
         job.level = '0;
      end else if (req_item.pixel == PIX_POS) begin
         job.level = top;
      end else if (run_max_ff < run_min_ff) begin
         job.level = '0;
      end else if (req_item.pixel <= run_min_ff) begin
         job.level = '0;
      end else if (req_item.pixel >= run_max_ff) begin
         job.level = top;
      end else begin
         job.direct = 1'b0;
      end
   end

   assign push_valid = accept && (req_item.func == FUNC_MAP);
   assign push_job   = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_bits_ff <= OUT_BITS_RESET;
         run_min_ff  <= PIX_POS;
         run_max_ff  <= PIX_NEG;
      end else begin
         out_bits_ff <= out_bits_in;
         run_min_ff  <= run_min_in;
         run_max_ff  <= run_max_in;
      end
   end

   // Once an ordinary pixel is gathered the range can no longer be empty.
   a_range_ordered : assert property (@(posedge clock) disable iff (reset)
      (accept && is_gather && !is_sentinel) |=> (run_max_ff >= run_min_ff))
      else $error("gathered range is inverted after a valid pixel");

endmodule
`default_nettype wire

### rtl/mmnorm_queue.sv
`default_nettype none
module mmnorm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  mmnorm_pkg::job_type  push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output mmnorm_pkg::job_type  head_job
);
   import mmnorm_pkg::*;

   job_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy beyond its depth");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("job offered while the queue is full");

endmodule
`default_nettype wire

### rtl/mmnorm_back.sv
`default_nettype none
module mmnorm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 empty,
   input  mmnorm_pkg::job_type  head_job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mmnorm_pkg::rsp_type  rsp_item
);
   import mmnorm_pkg::*;

   back_state_type           state_ff, state_in;
   job_type                  job_ff, job_in;
   logic [PRODUCT_W-1:0]     rem_ff, rem_in;
   logic [PRODUCT_W-1:0]     div_ff, div_in;
   logic [LEVEL_W-1:0]       quot_ff, quot_in;
   logic [STEP_CNT_W-1:0]    count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_item_ff, rsp_item_in;
   logic                     out_free;
   logic                     div_done;
   logic                     fits;
   logic [PRODUCT_W-1:0]     product;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign div_done = (count_ff == STEP_CNT_W'(LEVEL_W));
   assign fits     = (rem_ff >= div_ff);
   assign product  = {{PIXEL_W{1'b0}}, job_ff.top} * {{LEVEL_W{1'b0}}, job_ff.diff};

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quot_in      = quot_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      pop          = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!empty && (!head_job.direct || out_free)) begin
               pop    = 1'b1;
               job_in = head_job;
               if (head_job.direct) begin
                  rsp_valid_in      = 1'b1;
                  rsp_item_in.level = head_job.level;
                  rsp_item_in.flat  = head_job.flat;
               end else begin
                  state_in = BK_MUL;
               end
            end
         end
         BK_MUL: begin
            // The quotient is below full scale, so the divisor starts at
            // span shifted up by one less than the level width.
            rem_in   = product;
            div_in   = {{(LEVEL_W-LEVEL_W+1){1'b0}}, job_ff.span, {(LEVEL_W-1){1'b0}}};
            quot_in  = '0;
            count_in = '0;
            state_in = BK_DIV;
         end
         BK_DIV: begin
            if (!div_done) begin
               if (fits) begin
                  rem_in = rem_ff - div_ff;
               end
               quot_in  = {quot_ff[LEVEL_W-2:0], fits};
               div_in   = div_ff >> 1;
               count_in = count_ff + STEP_CNT_W'(1);
            end else if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_item_in.level = quot_ff;
               rsp_item_in.flat  = 1'b0;
               state_in          = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quot_ff     <= quot_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_quot_below_top : assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV && div_done) |-> (quot_ff < job_ff.top))
      else $error("quotient reached full scale on an interior pixel");

   a_rem_below_span : assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV && div_done)
         |-> (rem_ff < {{LEVEL_W{1'b0}}, job_ff.span}))
      else $error("division remainder not below the span");

   a_pop_needs_idle : assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == BK_IDLE && !empty))
      else $error("job taken while the back end is busy");

endmodule
`default_nettype wire

### rtl/minmax_normalize_to_nbits_unit.sv
// Min/max contrast stretch of signed 32-bit pixels to N-bit levels.
// Requests enter on req_valid/req_stall with req_item; a request is taken
// at a clock edge where req_valid is high and req_stall is low. Func restart
// and gather requests update the running minimum and maximum in the same
// cycle and give no response. Func map requests are classified at once and
// placed in a two-entry queue; the back end then delivers one response on
// rsp_valid/rsp_stall with rsp_item (level and flat).
// Pixels outside the range, sentinels and an empty or flat range are resolved
// at classification; their response passes through the queue and the output
// register, and such requests can follow one per cycle while the back end is
// idle and the output is not stalled. An interior pixel leaves the queue,
// passes a multiply step and a restoring divider (one quotient bit per cycle)
// and is then loaded into the output register; the back end takes no further
// job from the queue until then. Gather requests are taken one per cycle
// while the queue has room. The output register holds a response while
// rsp_stall is high; the queue absorbs up to two further map requests, after
// which req_stall rises. Synchronous reset sets the bit depth to eight,
// empties the range (minimum at the most positive value, maximum at the most
// negative) and drops any queued or pending response. csr_wr_en writes the bit
// depth; the user must assert it only while idle, which is not enforced.
`default_nettype none
module minmax_normalize_to_nbits_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  mmnorm_pkg::req_type                   req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output mmnorm_pkg::rsp_type                   rsp_item,
   input  logic                                  csr_wr_en,
   input  logic [mmnorm_pkg::OUT_BITS_W-1:0]     csr_wr_data
);
   import mmnorm_pkg::*;

   logic     push_valid;
   job_type  push_job;
   logic     queue_full;
   logic     queue_empty;
   logic     pop;
   job_type  head_job;

   // Front end: bit depth register, running range and request classification.
   mmnorm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   // The queue decouples classification from the divider.
   mmnorm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head_job   (head_job)
   );

   // Back end: multiply, iterative divide and the output register.
   mmnorm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (queue_empty),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire
